>>> design/world_to_screen_projection_assert.svh
// Assertion macros for the world-to-screen projection block.
// Clocked on clk, disabled while rst_n is low; empty under SYNTHESIS.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define WSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsp assertion failed");
`define WSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsp assertion failed");
`else
`define WSP_ASSERT_IMP(lbl, ante, cons)
`define WSP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/wsp_pkg.sv
// Types and constants of the world-to-screen projection block.
// No dependencies.
`timescale 1ns / 1ps
package wsp_pkg;
  localparam int COEF_COUNT = 16;
  localparam int SIZE_W     = 14;
  localparam int SUM_W      = 50;  // clip value, Q16.16, never wraps
  localparam int NUM_W      = 51;  // cw +/- cx
  localparam int DEN_W      = 50;  // 2*cw when visible
  localparam int PROD_W     = 65;  // size * numerator
  localparam int REM_W      = 64;  // magnitude of the product
  localparam int QBITS      = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int W_MIN_Q16  = 6554;  // 0.1 in Q16.16

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PROJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1080;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    value;
  } cfg_item_t;

  typedef struct packed {
    logic                    visible;
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic [DEN_W-1:0]        den;
  } xform_t;

  typedef struct packed {
    logic             visible;
    logic             neg_x;
    logic             neg_y;
    logic             sat_x;
    logic             sat_y;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [QBITS-1:0] q_x;
    logic [QBITS-1:0] q_y;
  } div_t;
endpackage

>>> design/wsp_stream_if.sv
// Valid/ready channel carrying one request of payload type T.
// No dependencies.
`timescale 1ns / 1ps
interface wsp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/wsp_transform.sv
// Matrix store and clip transform: input stage, products, row sums, numerators.
// Uses wsp_pkg.
`timescale 1ns / 1ps
module wsp_transform (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsp_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wsp_pkg::xform_t   out_data
);
  logic [3:0]               v_r;
  logic [3:0]               rdy;
  wsp_pkg::in_item_t        s0_r;
  logic signed [31:0]       matrix_r [wsp_pkg::COEF_COUNT];
  logic signed [63:0]       prod_r [3][3];
  logic signed [31:0]       bias_r [3];
  logic signed [wsp_pkg::SUM_W-1:0] sum_r [3];
  wsp_pkg::xform_t          out_r;
  logic signed [31:0]       coord [3];
  logic                     is_load;

  assign rdy[3] = out_ready || !v_r[3];
  assign rdy[2] = rdy[3] || !v_r[2];
  assign rdy[1] = rdy[2] || !v_r[1];
  assign rdy[0] = rdy[1] || !v_r[0];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[3];
  assign out_data  = out_r;

  assign coord[0] = s0_r.pos_x;
  assign coord[1] = s0_r.pos_y;
  assign coord[2] = s0_r.pos_z;
  assign is_load  = (s0_r.req_type == wsp_pkg::REQ_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0] && !is_load;
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  // loads update the store as they pass stage 1, in order with projects
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wsp_pkg::COEF_COUNT; i++) matrix_r[i] <= '0;
    end else if (rdy[1] && v_r[0] && is_load) begin
      matrix_r[s0_r.coef_index] <= s0_r.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) s0_r <= in_data;
    if (rdy[1]) begin
      // lanes 0, 1, 2 take matrix rows 0, 1, 3
      for (int l = 0; l < 3; l++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[l][c] <= matrix_r[(l == 2 ? 12 : l * 4) + c] * coord[c];
        end
        bias_r[l] <= matrix_r[(l == 2 ? 12 : l * 4) + 3];
      end
    end
    if (rdy[2]) begin
      for (int l = 0; l < 3; l++) begin
        sum_r[l] <= wsp_pkg::SUM_W'(bias_r[l])
                  + wsp_pkg::SUM_W'(prod_r[l][0] >>> 16)
                  + wsp_pkg::SUM_W'(prod_r[l][1] >>> 16)
                  + wsp_pkg::SUM_W'(prod_r[l][2] >>> 16);
      end
    end
    if (rdy[3]) begin
      out_r.visible <= !sum_r[2][wsp_pkg::SUM_W-1] &&
                       (sum_r[2][wsp_pkg::SUM_W-2:0] >=
                        (wsp_pkg::SUM_W-1)'(wsp_pkg::W_MIN_Q16));
      out_r.num_x <= wsp_pkg::NUM_W'(sum_r[2]) + wsp_pkg::NUM_W'(sum_r[0]);
      out_r.num_y <= wsp_pkg::NUM_W'(sum_r[2]) - wsp_pkg::NUM_W'(sum_r[1]);
      out_r.den   <= {sum_r[2][wsp_pkg::DEN_W-2:0], 1'b0};
    end
  end
endmodule

>>> design/wsp_scale.sv
// Viewport scaling: size times numerator, then sign fold and saturation check.
// Uses wsp_pkg.
`timescale 1ns / 1ps
module wsp_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [wsp_pkg::SIZE_W-1:0]  size_w,
  input  logic [wsp_pkg::SIZE_W-1:0]  size_h,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wsp_pkg::xform_t             in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wsp_pkg::div_t               out_data
);
  logic [1:0]                          v_r;
  logic [1:0]                          rdy;
  logic signed [wsp_pkg::PROD_W-1:0]   nx_r;
  logic signed [wsp_pkg::PROD_W-1:0]   ny_r;
  logic [wsp_pkg::DEN_W-1:0]           den_r;
  logic                                vis_r;
  wsp_pkg::div_t                       out_r;
  logic [wsp_pkg::REM_W-1:0]           ax;
  logic [wsp_pkg::REM_W-1:0]           ay;
  logic [wsp_pkg::PROD_W-1:0]          lim;

  assign rdy[1] = out_ready || !v_r[1];
  assign rdy[0] = rdy[1] || !v_r[0];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[1];
  assign out_data  = out_r;

  // floor(N/d) for negative N is ~floor(~N/d)
  assign ax  = nx_r[wsp_pkg::PROD_W-1] ? ~nx_r[wsp_pkg::REM_W-1:0] : nx_r[wsp_pkg::REM_W-1:0];
  assign ay  = ny_r[wsp_pkg::PROD_W-1] ? ~ny_r[wsp_pkg::REM_W-1:0] : ny_r[wsp_pkg::REM_W-1:0];
  assign lim = wsp_pkg::PROD_W'(den_r) << wsp_pkg::QBITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      nx_r  <= $signed({1'b0, size_w}) * in_data.num_x;
      ny_r  <= $signed({1'b0, size_h}) * in_data.num_y;
      den_r <= in_data.den;
      vis_r <= in_data.visible;
    end
    if (rdy[1]) begin
      out_r.visible <= vis_r;
      out_r.neg_x   <= nx_r[wsp_pkg::PROD_W-1];
      out_r.neg_y   <= ny_r[wsp_pkg::PROD_W-1];
      out_r.sat_x   <= {1'b0, ax} >= lim;
      out_r.sat_y   <= {1'b0, ay} >= lim;
      out_r.den     <= den_r;
      out_r.rem_x   <= ax;
      out_r.rem_y   <= ay;
      out_r.q_x     <= '0;
      out_r.q_y     <= '0;
    end
  end
endmodule

>>> design/wsp_div.sv
// Pipelined restoring divider, one quotient bit per stage for x and y.
// Uses wsp_pkg.
`timescale 1ns / 1ps
module wsp_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wsp_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wsp_pkg::div_t out_data
);
  localparam int N = wsp_pkg::QBITS;

  logic [N-1:0]  v_r;
  logic [N-1:0]  rdy;
  wsp_pkg::div_t st_r   [N];
  wsp_pkg::div_t st_nxt [N];

  function automatic wsp_pkg::div_t div_step(input wsp_pkg::div_t s, input int b);
    logic [wsp_pkg::REM_W-1:0] sh;
    wsp_pkg::div_t             r;
    r  = s;
    sh = wsp_pkg::REM_W'(s.den) << b;
    if (s.rem_x >= sh) begin
      r.rem_x  = s.rem_x - sh;
      r.q_x[b] = 1'b1;
    end
    if (s.rem_y >= sh) begin
      r.rem_y  = s.rem_y - sh;
      r.q_y[b] = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    rdy[N-1] = out_ready || !v_r[N-1];
    for (int k = N - 2; k >= 0; k--) rdy[k] = rdy[k+1] || !v_r[k];
    st_nxt[0] = div_step(in_data, N - 1);
    for (int k = 1; k < N; k++) st_nxt[k] = div_step(st_r[k-1], N - 1 - k);
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_data  = st_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < N; k++) if (rdy[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) if (rdy[k]) st_r[k] <= st_nxt[k];
  end
endmodule

>>> design/world_to_screen_projection.sv
// Top level of the world-to-screen projection block.
// Uses wsp_pkg, wsp_stream_if, wsp_transform, wsp_scale, wsp_div and the assert header.
`timescale 1ns / 1ps
`include "world_to_screen_projection_assert.svh"
// A fully pipelined point projector. Load requests (req_type 0) write one
// signed Q16.16 coefficient of the row-major 4x4 matrix and produce no result;
// project requests (req_type 1) produce exactly one result each, in order.
// One request is taken every cycle unless the full pipe is stalled; a project
// request's result passes through 4 stages of matrix products and row sums,
// 2 stages of viewport scaling, 15 divider stages (one quotient bit each)
// and the output register. Each stage holds when the one after it is full and
// stalled, so bubbles are squeezed out and back-pressure
// reaches in_req.ready only once the whole pipe is full. A load takes effect
// for every project request taken after it. The matrix resets to zero.
// screen_width/screen_height (reset 1920/1080) are written on cfg_wr, which
// is always ready; write them only while no project request is in flight.
// A point with w below 0.1 comes out with visible low and zero coordinates.
module world_to_screen_projection (
  input logic          clk,
  input logic          rst_n,
  wsp_stream_if.sink   in_req,
  wsp_stream_if.source out_res,
  wsp_stream_if.sink   cfg_wr
);
  logic [wsp_pkg::SIZE_W-1:0] width_r;
  logic [wsp_pkg::SIZE_W-1:0] height_r;

  logic            xf_valid, xf_ready;
  wsp_pkg::xform_t xf_data;
  logic            sc_valid, sc_ready;
  wsp_pkg::div_t   sc_data;
  logic            dv_valid, dv_ready;
  wsp_pkg::div_t   dv_data;

  logic              out_v_r;
  wsp_pkg::out_item_t out_r;
  logic              out_adv;

  wsp_pkg::in_item_t  in_item;
  wsp_pkg::cfg_item_t cfg_item;

  assign in_item  = in_req.data;
  assign cfg_item = cfg_wr.data;

  // configuration: always ready, unknown indexes are dropped
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= wsp_pkg::WIDTH_RESET;
      height_r <= wsp_pkg::HEIGHT_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_item.index)
        wsp_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_item.value;
        wsp_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_item.value;
        default: ;
      endcase
    end
  end

  wsp_transform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .in_data  (in_item),
    .out_valid(xf_valid),
    .out_ready(xf_ready),
    .out_data (xf_data)
  );

  wsp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .size_w   (width_r),
    .size_h   (height_r),
    .in_valid (xf_valid),
    .in_ready (xf_ready),
    .in_data  (xf_data),
    .out_valid(sc_valid),
    .out_ready(sc_ready),
    .out_data (sc_data)
  );

  wsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sc_valid),
    .in_ready (sc_ready),
    .in_data  (sc_data),
    .out_valid(dv_valid),
    .out_ready(dv_ready),
    .out_data (dv_data)
  );

  // output register: pick zero when not visible, else the saturation limit or the (sign-folded) quotient
  assign out_adv  = out_res.ready || !out_v_r;
  assign dv_ready = out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_r.visible <= dv_data.visible;
      if (!dv_data.visible) begin
        out_r.screen_x <= '0;
      end else if (dv_data.sat_x) begin
        out_r.screen_x <= dv_data.neg_x ? 16'sh8000 : 16'sh7fff;
      end else begin
        out_r.screen_x <= dv_data.neg_x ? ~{1'b0, dv_data.q_x} : {1'b0, dv_data.q_x};
      end
      if (!dv_data.visible) begin
        out_r.screen_y <= '0;
      end else if (dv_data.sat_y) begin
        out_r.screen_y <= dv_data.neg_y ? 16'sh8000 : 16'sh7fff;
      end else begin
        out_r.screen_y <= dv_data.neg_y ? ~{1'b0, dv_data.q_y} : {1'b0, dv_data.q_y};
      end
    end
  end

  assign out_res.valid = out_v_r;
  assign out_res.data  = out_r;

  `WSP_ASSERT_IMP(a_hidden_zero, out_v_r && !out_r.visible, out_r.screen_x == 16'sd0 && out_r.screen_y == 16'sd0)
  `WSP_ASSERT_IMP(a_empty_out_ready, !out_v_r, in_req.ready)
  `WSP_ASSERT_NXT(a_stall_holds, out_v_r && !out_res.ready, out_v_r && $stable(out_r))
endmodule

>>> dv/wsp_projection_checker.sv
// Checker for the world-to-screen projection block: watches the request,
// result and register-write channels, predicts each result and compares it.
// Depends on wsp_pkg.
`timescale 1ns / 1ps
module wsp_projection_checker
  import wsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_item_t cfg_data,
  output int        fail_count,
  output int        pending
);
  logic signed [31:0] coef_mem [COEF_COUNT];
  int unsigned        view_w;
  int unsigned        view_h;
  out_item_t          pixel_q[$];

  // clip value of one matrix row; each product floored to Q16.16
  function automatic longint clip_row(int r, longint x, longint y, longint z);
    longint acc;
    acc = longint'(coef_mem[4*r+3]);
    acc += (longint'(coef_mem[4*r+0]) * x) >>> 16;
    acc += (longint'(coef_mem[4*r+1]) * y) >>> 16;
    acc += (longint'(coef_mem[4*r+2]) * z) >>> 16;
    return acc;
  endfunction

  // floor(size*n/d), d > 0, saturated to 16 bits
  function automatic logic signed [15:0] to_pixel(int unsigned size, longint n, longint d);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = size;
    p = p * n;
    q = p / d;
    if ((p % d) != 0 && p < 0) q = q - 1;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic out_item_t project_point(in_item_t it);
    out_item_t r;
    longint    cx, cy, cw;
    cx = clip_row(0, it.pos_x, it.pos_y, it.pos_z);
    cy = clip_row(1, it.pos_x, it.pos_y, it.pos_z);
    cw = clip_row(3, it.pos_x, it.pos_y, it.pos_z);
    r = '0;
    if (cw >= W_MIN_Q16) begin
      r.visible  = 1'b1;
      r.screen_x = to_pixel(view_w, cw + cx, 2 * cw);
      r.screen_y = to_pixel(view_h, cw - cy, 2 * cw);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      foreach (coef_mem[i]) coef_mem[i] = '0;
      view_w = WIDTH_RESET;
      view_h = HEIGHT_RESET;
      pixel_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_data.index == CFG_SCREEN_WIDTH) view_w = cfg_data.value;
        else if (cfg_data.index == CFG_SCREEN_HEIGHT) view_h = cfg_data.value;
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected result %p", out_data);
          errs = errs + 1;
        end else begin
          want = pixel_q.pop_front();
          if (out_data.visible !== want.visible) begin
            $error("visible: expected %0d, got %0d", want.visible, out_data.visible);
            errs = errs + 1;
          end
          if (out_data.screen_x !== want.screen_x) begin
            $error("screen_x: expected %0d, got %0d", want.screen_x, out_data.screen_x);
            errs = errs + 1;
          end
          if (out_data.screen_y !== want.screen_y) begin
            $error("screen_y: expected %0d, got %0d", want.screen_y, out_data.screen_y);
            errs = errs + 1;
          end
        end
      end
      // prediction after the compare, so a same-edge project sees old queue
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_LOAD) coef_mem[in_data.coef_index] = in_data.coef_value;
        else pixel_q.push_back(project_point(in_data));
      end
      fail_count <= fail_count + errs;
    end
    pending <= pixel_q.size();
  end
endmodule

>>> dv/tb_world_to_screen_projection.sv
// Top of the world-to-screen projection testbench: clock, reset, request
// stimulus, register writes and the verdict. Depends on wsp_pkg,
// wsp_stream_if, the block and wsp_projection_checker.
`timescale 1ns / 1ps
module tb_world_to_screen_projection;
  import wsp_pkg::*;

  localparam int Q_ONE     = 32'h0001_0000;
  localparam int DRAIN_CYC = 40;        // pipe is 22 deep plus margin
  localparam int MAX_CYC   = 2_000_000;

  logic clk;
  logic rst_n;
  int   cycles;
  int   fail_count;
  int   pending;

  wsp_stream_if #(.T(in_item_t))  in_req ();
  wsp_stream_if #(.T(out_item_t)) out_res ();
  wsp_stream_if #(.T(cfg_item_t)) cfg_wr ();

  world_to_screen_projection u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  wsp_projection_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .in_data    (in_req.data),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_data   (out_res.data),
    .cfg_valid  (cfg_wr.valid),
    .cfg_ready  (cfg_wr.ready),
    .cfg_data   (cfg_wr.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the pipe hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("** world_to_screen_projection: FAILED **");
      $finish;
    end
  end

  // Result side back-pressure: alternates between always-ready stretches,
  // random stalls and long stalls so the full pipe backs up into in_req.
  int stall_mode;
  int mode_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_mode    <= 0;
      mode_left     <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(5, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_res.ready <= 1'b1;
        1: out_res.ready <= ($urandom_range(0, 1) == 1);
        default: out_res.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Sender burst state: requests go in bursts, gaps between them.
  int burst_left;

  // Push one request; valid stays high across back-to-back requests.
  task automatic send_req(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req.valid <= 1'b1;
    in_req.data  <= it;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic load_coef(int idx, logic signed [31:0] val);
    in_item_t it;
    it = '0;
    it.req_type   = REQ_LOAD;
    it.coef_index = 4'(idx);
    it.coef_value = val;
    it.pos_x      = $urandom;  // ignored on a load
    it.pos_y      = $urandom;
    it.pos_z      = $urandom;
    send_req(it);
  endtask

  task automatic project(logic signed [31:0] x, logic signed [31:0] y,
                         logic signed [31:0] z);
    in_item_t it;
    it.req_type   = REQ_PROJECT;
    it.coef_index = 4'($urandom);   // ignored on a project
    it.coef_value = $urandom;
    it.pos_x      = x;
    it.pos_y      = y;
    it.pos_z      = z;
    send_req(it);
  endtask

  // Wait for the pipe to drain, then write a viewport register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_wr.valid      <= 1'b1;
    cfg_wr.data.index <= idx;
    cfg_wr.data.value <= val;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Q16.16 value: full range, small world-scale, extremes or near zero.
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h4000)) - 32'sh2000;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // A plausible view-projection: small rows 0/1, w row positive-ish.
  task automatic load_view_matrix();
    for (int i = 0; i < COEF_COUNT; i++) begin
      if (i >= 12)
        load_coef(i, (i == 14) ? $signed($urandom_range(Q_ONE / 4, 4 * Q_ONE)) :
                  $signed($urandom_range(0, Q_ONE)) - Q_ONE / 2);
      else
        load_coef(i, $signed($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE);
    end
  endtask

  initial begin
    int phase_w [8] = '{1, 8192, 16383, 0, 640, 1, 3000, 8192};
    int phase_h [8] = '{1, 8192, 16383, 0, 480, 8192, 7, 1};
    cycles        = 0;
    rst_n         = 1'b0;
    burst_left    = 0;
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    cfg_wr.valid  = 1'b0;
    cfg_wr.data   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero matrix gives w = 0, so not visible.
    project(32'sh7fff_ffff, 32'sh8000_0000, Q_ONE);
    // identity-like rows: x, y pass through, w = z
    load_coef(0, Q_ONE);
    load_coef(5, Q_ONE);
    load_coef(14, Q_ONE);
    project(0, 0, Q_ONE);                  // viewport center
    project(Q_ONE, Q_ONE, Q_ONE);          // right/top edge
    project(-Q_ONE, -Q_ONE, Q_ONE);        // left/bottom edge
    project(0, 0, W_MIN_Q16);              // w exactly at the threshold
    project(0, 0, W_MIN_Q16 - 1);          // just below: not visible
    project(0, 0, -Q_ONE);                 // behind the camera
    project(32'sh7fff_ffff, 32'sh8000_0000, W_MIN_Q16);  // saturates both ways
    project(-Q_ONE / 3, Q_ONE / 7, 3 * Q_ONE);           // flooring of fractions
    load_coef(0, 32'sh8000_0000);          // coefficient extremes
    load_coef(1, 32'sh7fff_ffff);
    load_coef(15, 32'sh7fff_ffff);
    project(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    project(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    load_coef(15, 32'sh8000_0000);
    project(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    write_reg(8'd5, 14'h3fff);             // unmapped register index: no effect
    write_reg(8'hff, 14'h0001);
    project(Q_ONE / 2, -Q_ONE / 2, 32'sh7fff_ffff);

    // Random phases, each under a different viewport.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SCREEN_WIDTH, SIZE_W'(phase_w[ph]));
      write_reg(CFG_SCREEN_HEIGHT, SIZE_W'(phase_h[ph]));
      load_view_matrix();
      for (int n = 0; n < 80; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: load_coef($urandom_range(0, 15), rand_q16());
          3: project(rand_q16(), rand_q16(), rand_q16());
          default: project($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
                           $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
                           $signed($urandom_range(0, 32'h0080_0000)));
        endcase
        if ($urandom_range(0, 49) == 0) load_view_matrix();
      end
    end

    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** world_to_screen_projection: PASSED **");
    else
      $display("** world_to_screen_projection: FAILED **");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/wsp_pkg.sv
design/wsp_stream_if.sv
design/wsp_transform.sv
design/wsp_scale.sv
design/wsp_div.sv
design/world_to_screen_projection.sv
dv/wsp_projection_checker.sv
dv/tb_world_to_screen_projection.sv
